// ===== design/dcrm_pkg.sv =====
// Shared types and constants for the dirty cell rectangle merger.
package dcrm_pkg;

  // Register indexes on the configuration port
  localparam logic REG_GRID_COLS = 1'b0;
  localparam logic REG_GRID_ROWS = 1'b1;

  // Reset value of both grid size registers
  localparam logic [6:0] GRID_RESET = 7'd64;

  // Result queue geometry
  localparam int FIFO_DEPTH = 8;
  localparam int PTR_W      = 3;
  localparam int CNT_W      = 4;

  // One result item, rect_col in the lowest bits
  typedef struct packed {
    logic       frame_end;
    logic       rect_valid;
    logic [6:0] rect_rows;
    logic [6:0] rect_cols;
    logic [5:0] rect_row;
    logic [5:0] rect_col;
  } rect_t;

  // Per-cell control handed from the compare stage to the merge logic
  typedef struct packed {
    logic valid;
    logic changed;
    logic frame_last;
  } cell_ctl_t;

endpackage

// ===== design/dcrm_hash_store.sv =====
// Previous-frame hash memory with a zeroing sweep after reset.
module dcrm_hash_store #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12,
  parameter int HW    = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [HW-1:0] rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [HW-1:0] wr_data,
  output logic          busy
);

  logic [HW-1:0] mem [DEPTH];
  logic [AW-1:0] clr_addr;

  // Clear sweep, one entry per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b1;
      clr_addr <= '0;
    end else if (busy) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == AW'(DEPTH - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  // Single write port, shared by the sweep and the write-back
  always_ff @(posedge clk) begin
    if (busy) begin
      mem[clr_addr] <= '0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== design/dcrm_merge.sv =====
// Pending rectangle register and merge / emit decision.
module dcrm_merge #(
  parameter int XW = 7,
  parameter int YW = 7
) (
  input  logic              clk,
  input  logic              rst,
  input  dcrm_pkg::cell_ctl_t ctl,
  input  logic [XW-1:0]     col,
  input  logic [YW-1:0]     row,
  output logic [1:0]        push_cnt,
  output dcrm_pkg::rect_t   res0,
  output dcrm_pkg::rect_t   res1
);

  logic [XW-1:0] pend_col, pend_col_next;
  logic [YW-1:0] pend_row, pend_row_next;
  logic [XW-1:0] pend_cols, pend_cols_next;
  logic [YW-1:0] pend_rows, pend_rows_next;
  logic          pend_valid, pend_valid_next;

  logic [XW:0] col1, pend_x2, x1, x2;
  logic [YW:0] row1, pend_y2, y1, y2;
  logic        touch;
  logic        emit_old;
  logic [XW-1:0] u_col, u_cols;
  logic [YW-1:0] u_row, u_rows;
  logic          u_valid;
  dcrm_pkg::rect_t old_r, fin_r;
  logic [31:0] t_c, t_r, t_w, t_h;

  // Bounds of the cell and of the pending rectangle
  assign col1    = (XW+1)'(col) + (XW+1)'(1);
  assign row1    = (YW+1)'(row) + (YW+1)'(1);
  assign pend_x2 = (XW+1)'(pend_col) + (XW+1)'(pend_cols);
  assign pend_y2 = (YW+1)'(pend_row) + (YW+1)'(pend_rows);

  assign touch = pend_valid &&
                 col1 >= (XW+1)'(pend_col) && (XW+1)'(col) <= pend_x2 &&
                 row1 >= (YW+1)'(pend_row) && (YW+1)'(row) <= pend_y2;

  // Bounding box of cell and pending rectangle
  assign x1 = (col < pend_col) ? (XW+1)'(col) : (XW+1)'(pend_col);
  assign y1 = (row < pend_row) ? (YW+1)'(row) : (YW+1)'(pend_row);
  assign x2 = (col1 > pend_x2) ? col1 : pend_x2;
  assign y2 = (row1 > pend_y2) ? row1 : pend_y2;

  // Updated pending rectangle after this cell
  always_comb begin
    u_col    = pend_col;
    u_row    = pend_row;
    u_cols   = pend_cols;
    u_rows   = pend_rows;
    u_valid  = pend_valid;
    emit_old = 1'b0;
    if (ctl.changed) begin
      if (touch) begin
        u_col  = XW'(x1);
        u_row  = YW'(y1);
        u_cols = XW'(x2 - x1);
        u_rows = YW'(y2 - y1);
      end else begin
        emit_old = pend_valid;
        u_col    = col;
        u_row    = row;
        u_cols   = XW'(1);
        u_rows   = YW'(1);
        u_valid  = 1'b1;
      end
    end
  end

  // Result entries, coordinates cut to the port widths
  always_comb begin
    t_c = 32'(pend_col);
    t_r = 32'(pend_row);
    t_w = 32'(pend_cols);
    t_h = 32'(pend_rows);
    old_r.rect_col   = t_c[5:0];
    old_r.rect_row   = t_r[5:0];
    old_r.rect_cols  = t_w[6:0];
    old_r.rect_rows  = t_h[6:0];
    old_r.rect_valid = 1'b1;
    old_r.frame_end  = 1'b0;

    t_c = 32'(u_col);
    t_r = 32'(u_row);
    t_w = 32'(u_cols);
    t_h = 32'(u_rows);
    fin_r.rect_col   = u_valid ? t_c[5:0] : 6'd0;
    fin_r.rect_row   = u_valid ? t_r[5:0] : 6'd0;
    fin_r.rect_cols  = u_valid ? t_w[6:0] : 7'd0;
    fin_r.rect_rows  = u_valid ? t_h[6:0] : 7'd0;
    fin_r.rect_valid = u_valid;
    fin_r.frame_end  = 1'b1;
  end

  // Pack the results in order: old rectangle first, then the frame end
  always_comb begin
    push_cnt = 2'd0;
    res0     = fin_r;
    res1     = fin_r;
    if (ctl.valid) begin
      if (emit_old) begin
        res0     = old_r;
        push_cnt = ctl.frame_last ? 2'd2 : 2'd1;
      end else begin
        push_cnt = ctl.frame_last ? 2'd1 : 2'd0;
      end
    end
  end

  // Next pending state; cleared at frame end
  always_comb begin
    pend_col_next   = pend_col;
    pend_row_next   = pend_row;
    pend_cols_next  = pend_cols;
    pend_rows_next  = pend_rows;
    pend_valid_next = pend_valid;
    if (ctl.valid) begin
      if (ctl.frame_last) begin
        pend_col_next   = '0;
        pend_row_next   = '0;
        pend_cols_next  = '0;
        pend_rows_next  = '0;
        pend_valid_next = 1'b0;
      end else begin
        pend_col_next   = u_col;
        pend_row_next   = u_row;
        pend_cols_next  = u_cols;
        pend_rows_next  = u_rows;
        pend_valid_next = u_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_col   <= '0;
      pend_row   <= '0;
      pend_cols  <= '0;
      pend_rows  <= '0;
      pend_valid <= 1'b0;
    end else begin
      pend_col   <= pend_col_next;
      pend_row   <= pend_row_next;
      pend_cols  <= pend_cols_next;
      pend_rows  <= pend_rows_next;
      pend_valid <= pend_valid_next;
    end
  end

endmodule

// ===== design/dcrm_out_fifo.sv =====
// Result queue: up to two pushes per cycle, one pop.
module dcrm_out_fifo (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [1:0]                    push_cnt,
  input  dcrm_pkg::rect_t               din0,
  input  dcrm_pkg::rect_t               din1,
  input  logic                          pop,
  output logic                          not_empty,
  output dcrm_pkg::rect_t               dout,
  output logic [dcrm_pkg::CNT_W-1:0]    count
);

  dcrm_pkg::rect_t               q [dcrm_pkg::FIFO_DEPTH];
  logic [dcrm_pkg::PTR_W-1:0]    wptr, rptr;
  logic [dcrm_pkg::PTR_W-1:0]    wptr1;
  logic                          do_pop;

  assign not_empty = (count != '0);
  assign dout      = q[rptr];
  assign do_pop    = pop && not_empty;
  assign wptr1     = wptr + 1'b1;

  // Entry writes
  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) begin
      q[wptr] <= din0;
    end
    if (push_cnt == 2'd2) begin
      q[wptr1] <= din1;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      wptr  <= wptr + dcrm_pkg::PTR_W'(push_cnt);
      rptr  <= rptr + dcrm_pkg::PTR_W'(do_pop);
      count <= count + dcrm_pkg::CNT_W'(push_cnt) - dcrm_pkg::CNT_W'(do_pop);
    end
  end

endmodule

// ===== design/dirty_cell_rect_merger_unit.sv =====
// A cell's results pass the compare stage registers and the result queue on the way to the output.
// Throughput: one cell hash per cycle while input ready is high; the memory read is issued at
// acceptance and the write-back follows from the compare stage registers, forwarded when the
// next cell reuses the entry. Input ready drops while the result queue lacks room for two more
// results each for the in-flight and the offered cell. Reset: synchronous; then a sweep over all
// MAX_COLS*MAX_ROWS entries (4096 by default) zeroes the memory, input ready low.
module dirty_cell_rect_merger_unit #(
  parameter int MAX_COLS  = 64,
  parameter int MAX_ROWS  = 64,
  parameter int HASH_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  // configuration write port
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [6:0]  cfg_wdata,
  // cell hash stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] cell_hash
  // rectangle stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [5:0] rect_col, [11:6] rect_row,
                                      // [18:12] rect_cols, [25:19] rect_rows, zero fill
  output logic [0:0]  m_axis_tuser,   // [0] rect_valid
  output logic        m_axis_tlast    // frame_end
);

  localparam int DEPTH = MAX_COLS * MAX_ROWS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int XW    = $clog2(MAX_COLS + 1);
  localparam int YW    = $clog2(MAX_ROWS + 1);

  logic [6:0]     grid_cols, grid_rows;
  logic [XW-1:0]  cols_eff;
  logic [YW-1:0]  rows_eff;
  logic [31:0]    t_cols, t_rows;

  logic [XW-1:0]  scan_col;
  logic [YW-1:0]  scan_row;
  logic [AW-1:0]  cur_addr;
  logic           row_end, frame_last;
  logic [63:0]    hash_ext;
  logic [HASH_BITS-1:0] in_hash;
  logic           accept;
  logic           busy;

  logic                 s1_valid;
  logic [AW-1:0]        s1_addr;
  logic [XW-1:0]        s1_col;
  logic [YW-1:0]        s1_row;
  logic [HASH_BITS-1:0] s1_hash;
  logic                 s1_last;
  logic                 s1_fwd;
  logic [HASH_BITS-1:0] s1_fwd_hash;
  logic [HASH_BITS-1:0] rd_data;
  logic [HASH_BITS-1:0] stored_hash;

  dcrm_pkg::cell_ctl_t  ctl;
  dcrm_pkg::rect_t      res0, res1, head;
  logic [1:0]           push_cnt;
  logic [dcrm_pkg::CNT_W-1:0] fifo_cnt;
  logic [dcrm_pkg::CNT_W:0]   need;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_cols <= dcrm_pkg::GRID_RESET;
      grid_rows <= dcrm_pkg::GRID_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        dcrm_pkg::REG_GRID_COLS: grid_cols <= cfg_wdata;
        dcrm_pkg::REG_GRID_ROWS: grid_rows <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Grid size in use: zero acts as one, clipped to the maximum
  always_comb begin
    if (grid_cols == 7'd0) begin
      t_cols = 32'd1;
    end else if (32'(grid_cols) > MAX_COLS) begin
      t_cols = 32'(MAX_COLS);
    end else begin
      t_cols = 32'(grid_cols);
    end
    if (grid_rows == 7'd0) begin
      t_rows = 32'd1;
    end else if (32'(grid_rows) > MAX_ROWS) begin
      t_rows = 32'(MAX_ROWS);
    end else begin
      t_rows = 32'(grid_rows);
    end
  end
  assign cols_eff = t_cols[XW-1:0];
  assign rows_eff = t_rows[YW-1:0];

  // Scan position and address of the incoming cell
  assign cur_addr   = AW'(32'(scan_row) * MAX_COLS + 32'(scan_col));
  assign row_end    = ((XW+1)'(scan_col) + (XW+1)'(1)) >= (XW+1)'(cols_eff);
  assign frame_last = row_end && (((YW+1)'(scan_row) + (YW+1)'(1)) >= (YW+1)'(rows_eff));
  assign hash_ext   = 64'(s_axis_tdata);
  assign in_hash    = hash_ext[HASH_BITS-1:0];

  // Room for the in-flight cell's and this cell's results, two each
  assign need = (dcrm_pkg::CNT_W+1)'(fifo_cnt)
              + (s1_valid ? (dcrm_pkg::CNT_W+1)'(2) : '0)
              + (dcrm_pkg::CNT_W+1)'(2);
  assign s_axis_tready = !busy && (need <= (dcrm_pkg::CNT_W+1)'(dcrm_pkg::FIFO_DEPTH));
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_col <= '0;
      scan_row <= '0;
    end else if (accept) begin
      if (frame_last) begin
        scan_col <= '0;
        scan_row <= '0;
      end else if (row_end) begin
        scan_col <= '0;
        scan_row <= scan_row + 1'b1;
      end else begin
        scan_col <= scan_col + 1'b1;
      end
    end
  end

  // Compare stage registers
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_addr     <= cur_addr;
      s1_col      <= scan_col;
      s1_row      <= scan_row;
      s1_hash     <= in_hash;
      s1_last     <= frame_last;
      s1_fwd      <= s1_valid && (s1_addr == cur_addr);
      s1_fwd_hash <= s1_hash;
    end
  end

  dcrm_hash_store #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .HW    (HASH_BITS)
  ) u_store (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (accept),
    .rd_addr (cur_addr),
    .rd_data (rd_data),
    .wr_en   (s1_valid),
    .wr_addr (s1_addr),
    .wr_data (s1_hash),
    .busy    (busy)
  );

  // Write-back of the previous cell lands on the same edge as this read
  assign stored_hash    = s1_fwd ? s1_fwd_hash : rd_data;
  assign ctl.valid      = s1_valid;
  assign ctl.changed    = stored_hash != s1_hash;
  assign ctl.frame_last = s1_last;

  dcrm_merge #(
    .XW (XW),
    .YW (YW)
  ) u_merge (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl),
    .col      (s1_col),
    .row      (s1_row),
    .push_cnt (push_cnt),
    .res0     (res0),
    .res1     (res1)
  );

  dcrm_out_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push_cnt  (push_cnt),
    .din0      (res0),
    .din1      (res1),
    .pop       (m_axis_tready),
    .not_empty (m_axis_tvalid),
    .dout      (head),
    .count     (fifo_cnt)
  );

  // Output packing
  assign m_axis_tdata = {6'd0, head.rect_rows, head.rect_cols, head.rect_row, head.rect_col};
  assign m_axis_tuser = head.rect_valid;
  assign m_axis_tlast = head.frame_end;

endmodule

// ===== design/dcrm_checker.sv =====
// Port-level checks for the dirty cell rectangle merger, bound to the top level.
module dcrm_port_checks (
  input logic        clk,
  input logic        rst,
  input logic        cfg_we,
  input logic        cfg_addr,
  input logic [6:0]  cfg_wdata,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [31:0] s_axis_tdata,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic [0:0]  m_axis_tuser,
  input logic        m_axis_tlast
);

  // A stalled result stays offered
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  // An empty result is always a frame end with zero fields
  a_empty: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tlast && (m_axis_tdata == 32'd0))
    else $error("empty result malformed");

  // A carried rectangle has nonzero size
  a_size: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[0] |->
      (m_axis_tdata[18:12] != 7'd0) && (m_axis_tdata[25:19] != 7'd0))
    else $error("rectangle of zero size");

  // Memory sweep holds off input right after reset
  a_sweep: assert property (@(posedge clk) rst |=> !s_axis_tready)
    else $error("input ready during clear sweep");

  // Nothing is left queued across reset
  a_flush: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result present after reset");

endmodule

bind dirty_cell_rect_merger_unit dcrm_port_checks u_dcrm_checker (.*);

// ===== tb/dcrm_checker.sv =====
// Checker for the dirty cell rectangle merger: tracks requests, predicts rectangles, compares.
module dcrm_checker #(
  parameter int MAX_COLS = 64,
  parameter int MAX_ROWS = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [6:0]  cfg_wdata,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] cell_hash
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [31:0] m_axis_tdata,   // [5:0] rect_col, [11:6] rect_row,
                                      // [18:12] rect_cols, [25:19] rect_rows, zero fill
  input  logic [0:0]  m_axis_tuser,   // [0] rect_valid
  input  logic        m_axis_tlast,   // frame_end
  output int          err_count,
  output int          rects_due
);
  timeunit 1ns;
  timeprecision 1ps;

  // Shadow of the grid registers
  logic [6:0]  grid_cols;
  logic [6:0]  grid_rows;

  // Last frame's hash per cell, row * MAX_COLS + col
  logic [31:0] last_hash [MAX_COLS * MAX_ROWS];

  // Scan position and the open rectangle
  logic [5:0]  scan_c;
  logic [5:0]  scan_r;
  logic [5:0]  box_c;
  logic [5:0]  box_r;
  logic [6:0]  box_w;
  logic [6:0]  box_h;
  logic        box_live;

  // Rectangles predicted but not yet seen on the output
  dcrm_pkg::rect_t rect_q [$];
  int              errs;

  // Out-of-range sizes: 0 acts as 1, anything above the maximum as the maximum
  function automatic int clamp_dim(input logic [6:0] v, input int maxv);
    if (v == 0) return 1;
    if (int'(v) > maxv) return maxv;
    return int'(v);
  endfunction

  function automatic dcrm_pkg::rect_t make_rect(input int c, input int r, input int w,
                                                input int h, input logic ok,
                                                input logic fe);
    dcrm_pkg::rect_t t;
    t.rect_col   = 6'(c);
    t.rect_row   = 6'(r);
    t.rect_cols  = 7'(w);
    t.rect_rows  = 7'(h);
    t.rect_valid = ok;
    t.frame_end  = fe;
    return t;
  endfunction

  // Compare the cell with last frame, merge or flush, and close the frame on its last cell
  task automatic take_hash(input logic [31:0] h);
    int cols, rows, c, r, addr, x1, y1, x2, y2;
    bit row_end, frame_done;
    cols = clamp_dim(grid_cols, MAX_COLS);
    rows = clamp_dim(grid_rows, MAX_ROWS);
    c    = int'(scan_c);
    r    = int'(scan_r);
    addr = r * MAX_COLS + c;
    if (last_hash[addr] !== h) begin
      // inclusive bounds: touching the open box counts as overlap
      if (box_live && c + 1 >= int'(box_c) && c <= int'(box_c) + int'(box_w) &&
          r + 1 >= int'(box_r) && r <= int'(box_r) + int'(box_h)) begin
        x1 = (c < int'(box_c)) ? c : int'(box_c);
        y1 = (r < int'(box_r)) ? r : int'(box_r);
        x2 = (c + 1 > int'(box_c) + int'(box_w)) ? c + 1 : int'(box_c) + int'(box_w);
        y2 = (r + 1 > int'(box_r) + int'(box_h)) ? r + 1 : int'(box_r) + int'(box_h);
        box_c = 6'(x1);
        box_r = 6'(y1);
        box_w = 7'(x2 - x1);
        box_h = 7'(y2 - y1);
      end else begin
        if (box_live) rect_q.push_back(make_rect(box_c, box_r, box_w, box_h, 1'b1, 1'b0));
        box_c    = 6'(c);
        box_r    = 6'(r);
        box_w    = 7'd1;
        box_h    = 7'd1;
        box_live = 1'b1;
      end
    end
    last_hash[addr] = h;

    // a row or frame ends at or beyond the last column / row in use
    row_end    = (c + 1 >= cols);
    frame_done = row_end && (r + 1 >= rows);
    if (frame_done) begin
      if (box_live) rect_q.push_back(make_rect(box_c, box_r, box_w, box_h, 1'b1, 1'b1));
      else rect_q.push_back(make_rect(0, 0, 0, 0, 1'b0, 1'b1));
      box_live = 1'b0;
      box_c    = '0;
      box_r    = '0;
      box_w    = '0;
      box_h    = '0;
      scan_c   = '0;
      scan_r   = '0;
    end else if (row_end) begin
      scan_c = '0;
      scan_r = 6'(r + 1);
    end else begin
      scan_c = 6'(c + 1);
    end
  endtask

  task automatic cmp_field(input string name, input logic [31:0] want,
                           input logic [31:0] got);
    if (got !== want) begin
      errs++;
      $error("%s: expected %0d, got %0d", name, want, got);
    end
  endtask

  task automatic check_rect();
    dcrm_pkg::rect_t want;
    if (rect_q.size() == 0) begin
      errs++;
      $error("rectangle with none expected: tdata %h tuser %b tlast %b",
             m_axis_tdata, m_axis_tuser, m_axis_tlast);
    end else begin
      want = rect_q.pop_front();
      cmp_field("rect_col", 32'(want.rect_col), 32'(m_axis_tdata[5:0]));
      cmp_field("rect_row", 32'(want.rect_row), 32'(m_axis_tdata[11:6]));
      cmp_field("rect_cols", 32'(want.rect_cols), 32'(m_axis_tdata[18:12]));
      cmp_field("rect_rows", 32'(want.rect_rows), 32'(m_axis_tdata[25:19]));
      cmp_field("rect_valid", 32'(want.rect_valid), 32'(m_axis_tuser[0]));
      cmp_field("frame_end", 32'(want.frame_end), 32'(m_axis_tlast));
      cmp_field("tdata fill", 32'd0, 32'(m_axis_tdata[31:26]));
    end
  endtask

  // Everything is sampled at the clock edge; counts go out registered
  always @(posedge clk) begin
    if (rst) begin
      grid_cols = dcrm_pkg::GRID_RESET;
      grid_rows = dcrm_pkg::GRID_RESET;
      foreach (last_hash[i]) last_hash[i] = '0;
      scan_c   = '0;
      scan_r   = '0;
      box_c    = '0;
      box_r    = '0;
      box_w    = '0;
      box_h    = '0;
      box_live = 1'b0;
      rect_q.delete();
      errs     = 0;
    end else begin
      if (cfg_we) begin
        if (cfg_addr == dcrm_pkg::REG_GRID_COLS) grid_cols = cfg_wdata;
        else grid_rows = cfg_wdata;
      end
      if (s_axis_tvalid && s_axis_tready) take_hash(s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) check_rect();
    end
    err_count <= errs;
    rects_due <= rect_q.size();
  end

endmodule

// ===== tb/tb_top.sv =====
// Testbench top for the dirty cell rectangle merger: clock, reset, stimulus and verdict.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int RANDOM_CELLS = 2000;
  localparam int DRAIN_CYCLES = 8;
  localparam int MAX_DIM      = 64;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic        cfg_addr;
  logic [6:0]  cfg_wdata;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;
  logic [0:0]  m_axis_tuser;
  logic        m_axis_tlast;
  int          err_count;
  int          rects_due;

  // Stimulus bookkeeping
  logic [6:0]  cur_cols;
  logic [6:0]  cur_rows;
  bit          quiet;
  int          cells_sent;

  dirty_cell_rect_merger_unit dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  dcrm_checker checker_i (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .err_count     (err_count),
    .rects_due     (rects_due)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Hard stop; allows for the hash clearing sweep after reset
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("DONE: errors detected");
    $finish;
  end

  // Sender gaps: mostly none, some short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  function automatic int dim_of(input logic [6:0] v);
    if (v == 0) return 1;
    if (int'(v) > MAX_DIM) return MAX_DIM;
    return int'(v);
  endfunction

  // Output side: alternating ready runs and stalls, no stalls while quiet
  initial begin : sink
    int  left;
    bit  want;
    left = 0;
    want = 1'b0;
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (left == 0) begin
        want = quiet ? 1'b1 : !want;
        if (want) left = $urandom_range(1, 24);
        else if ($urandom_range(0, 9) < 8) left = $urandom_range(1, 3);
        else left = $urandom_range(5, 30);
      end
      m_axis_tready <= want;
      left--;
    end
  end

  // One hash request; valid stays up afterwards unless the next request idles first
  task automatic send_hash(input logic [31:0] h);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= h;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    cells_sent++;
  endtask

  task automatic cfg_write(input logic idx, input logic [6:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    if (idx == dcrm_pkg::REG_GRID_COLS) cur_cols = val;
    else cur_rows = val;
  endtask

  // Hold requests until every predicted rectangle is out and the pipe is empty
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (rects_due != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    logic [31:0] split_pat [6];
    logic [31:0] merge_pat [6];
    logic [31:0] base;
    int          shape, mode, per_frame, n, start;

    split_pat = '{32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0, 32'h0, 32'h1};
    merge_pat = '{32'hFFFF_FFFF, 32'h5, 32'h6, 32'h7, 32'h0, 32'h1};
    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_addr      = dcrm_pkg::REG_GRID_COLS;
    cfg_wdata     = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    quiet         = 1'b0;
    cur_cols      = dcrm_pkg::GRID_RESET;
    cur_rows      = dcrm_pkg::GRID_RESET;
    cells_sent    = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // 3x2 grid: corner cells changed and apart, two rectangles on the last cell
    cfg_write(dcrm_pkg::REG_GRID_COLS, 7'd3);
    cfg_write(dcrm_pkg::REG_GRID_ROWS, 7'd2);
    foreach (split_pat[i]) send_hash(split_pat[i]);
    // identical frame: empty frame end
    foreach (split_pat[i]) send_hash(split_pat[i]);
    // adjacent and diagonal changes merge into one 3x2 box
    foreach (merge_pat[i]) send_hash(merge_pat[i]);

    // width shrinks below the scan column mid-frame: row ends at once
    send_hash(32'h8);
    send_hash(32'h9);
    drain();
    cfg_write(dcrm_pkg::REG_GRID_COLS, 7'd2);
    send_hash(32'hA);
    send_hash(32'hB);
    send_hash(32'hC);

    // height shrinks below the scan row mid-frame: frame ends on that row
    drain();
    cfg_write(dcrm_pkg::REG_GRID_COLS, 7'd1);
    cfg_write(dcrm_pkg::REG_GRID_ROWS, 7'd3);
    send_hash(32'h8000_0000);
    send_hash(32'h7FFF_FFFF);
    drain();
    cfg_write(dcrm_pkg::REG_GRID_ROWS, 7'd1);
    send_hash(32'h0000_FFFF);

    // zero sizes act as a 1x1 grid
    drain();
    cfg_write(dcrm_pkg::REG_GRID_COLS, 7'd0);
    cfg_write(dcrm_pkg::REG_GRID_ROWS, 7'd0);
    send_hash(32'h1234_5678);
    send_hash(32'h1234_5678);

    // Random phases: new sizes between phases, partial frames carry over
    start = cells_sent;
    while (cells_sent - start < RANDOM_CELLS) begin
      drain();
      shape = $urandom_range(0, 9);
      if (shape == 0) begin
        // full-width strip, at or above the maximum
        cfg_write(dcrm_pkg::REG_GRID_COLS,
                  $urandom_range(0, 1) ? 7'd64 : 7'($urandom_range(65, 127)));
        cfg_write(dcrm_pkg::REG_GRID_ROWS, 7'($urandom_range(0, 2)));
      end else if (shape == 1) begin
        // full-height strip
        cfg_write(dcrm_pkg::REG_GRID_COLS, 7'($urandom_range(0, 2)));
        cfg_write(dcrm_pkg::REG_GRID_ROWS,
                  $urandom_range(0, 1) ? 7'd64 : 7'($urandom_range(65, 127)));
      end else if (shape == 2) begin
        cfg_write(dcrm_pkg::REG_GRID_COLS, 7'($urandom_range(0, 8)));
      end else if (shape == 3) begin
        cfg_write(dcrm_pkg::REG_GRID_ROWS, 7'($urandom_range(0, 8)));
      end else begin
        cfg_write(dcrm_pkg::REG_GRID_COLS, 7'($urandom_range(0, 8)));
        cfg_write(dcrm_pkg::REG_GRID_ROWS, 7'($urandom_range(0, 8)));
      end
      per_frame = dim_of(cur_cols) * dim_of(cur_rows);
      n         = per_frame * $urandom_range(1, 3) + $urandom_range(0, per_frame - 1);
      mode      = $urandom_range(0, 3);
      base      = $urandom;
      quiet     = ($urandom_range(0, 4) == 0);
      for (int i = 0; i < n; i++) begin
        case (mode)
          0:       send_hash($urandom);                                // every cell changes
          1:       send_hash($urandom_range(0, 1) ? base : ~base);     // about half change
          2:       send_hash($urandom_range(0, 15) == 0 ? $urandom : base); // sparse
          default: send_hash(base);                                    // settles to no change
        endcase
      end
    end

    quiet = 1'b0;
    drain();
    if (err_count == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule
